// File: hw/rtl/fccd_pkg.sv
// Shared types, constants and the case-conversion function of the
// framed case-convert deframer. No dependencies.
package fccd_pkg;

  localparam int unsigned PAYLOAD_DEPTH = 64;
  localparam int unsigned ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int unsigned LEN_W         = 7;

  localparam logic [7:0] START_BYTE = 8'h55;
  localparam logic [7:0] END_BYTE   = 8'hAA;

  localparam logic [7:0] OP_UPPER = 8'h00;
  localparam logic [7:0] OP_LOWER = 8'h01;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(64);
  localparam logic             REG_MAX_PAYLOAD   = 1'b0;

  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] len;
    logic [7:0]       op;
  } fccd_start_t;

  function automatic logic [7:0] convert_case(input logic [7:0] b, input logic [7:0] op);
    logic [7:0] r;
    r = b;
    if (op == OP_UPPER && b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'h20;
    end else if (op == OP_LOWER && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/fccd_payload_ram.sv
// Payload store: one write port, one read port, registered read data.
// Depends on fccd_pkg for depth and address width.
module fccd_payload_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [fccd_pkg::ADDR_W-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic                      re_i,
  input  logic [fccd_pkg::ADDR_W-1:0] raddr_i,
  output logic [7:0]                rdata_o
);
  import fccd_pkg::*;

  logic [7:0] mem [PAYLOAD_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: hw/rtl/fccd_parser.sv
// Frame header parser: hunts for the start byte, holds operation and length,
// writes payload bytes into the store and requests a drain on a good end byte.
// Depends on fccd_pkg.
module fccd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rx_fire_i,
  input  logic [7:0]                 rx_byte_i,
  input  logic [fccd_pkg::LEN_W-1:0] max_payload_i,
  output logic                       we_o,
  output logic [fccd_pkg::ADDR_W-1:0] waddr_o,
  output logic [7:0]                 wdata_o,
  output fccd_pkg::fccd_start_t      start_o
);
  import fccd_pkg::*;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_OP   = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_DATA = 5'b01000,
    PH_END  = 5'b10000
  } fccd_phase_e;

  fccd_phase_e      phase_q, phase_d;
  logic [7:0]       op_q, op_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] cnt_inc;

  assign limit   = (max_payload_i > LEN_W'(PAYLOAD_DEPTH)) ? LEN_W'(PAYLOAD_DEPTH)
                                                           : max_payload_i;
  assign cnt_inc = cnt_q + LEN_W'(1);

  always_comb begin
    phase_d       = phase_q;
    op_d          = op_q;
    len_d         = len_q;
    cnt_d         = cnt_q;
    we_o          = 1'b0;
    waddr_o       = cnt_q[ADDR_W-1:0];
    wdata_o       = rx_byte_i;
    start_o.valid = 1'b0;
    start_o.len   = len_q;
    start_o.op    = op_q;
    if (rx_fire_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == START_BYTE) begin
            phase_d = PH_OP;
            cnt_d   = '0;
          end
        end
        PH_OP: begin
          op_d    = rx_byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (rx_byte_i > {1'b0, limit}) begin
            phase_d = PH_HUNT;
          end else begin
            len_d   = rx_byte_i[LEN_W-1:0];
            cnt_d   = '0;
            phase_d = (rx_byte_i == 8'h00) ? PH_END : PH_DATA;
          end
        end
        PH_DATA: begin
          we_o  = (cnt_q < LEN_W'(PAYLOAD_DEPTH));
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_END;
          end
        end
        PH_END: begin
          start_o.valid = (rx_byte_i == END_BYTE) && (len_q != '0);
          phase_d       = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      op_q    <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/fccd_drain.sv
// Payload drain: reads the store entry by entry, converts case and holds
// each result in an output register until the receiver takes it.
// Depends on fccd_pkg.
module fccd_drain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fccd_pkg::fccd_start_t       start_i,
  output logic                        busy_o,
  output logic                        re_o,
  output logic [fccd_pkg::ADDR_W-1:0] raddr_o,
  input  logic [7:0]                  rdata_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [7:0]                  m_tdata_o,
  output logic [7:0]                  m_tuser_o,
  output logic                        m_tlast_o
);
  import fccd_pkg::*;

  logic             active_q;
  logic [7:0]       op_q;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] ptr_q;
  logic             pend_q, pend_last_q;
  logic             out_valid_q, out_last_q;
  logic [7:0]       out_data_q;
  logic             out_fire, issue;

  assign out_fire = out_valid_q & m_tready_i;
  assign issue    = active_q & (ptr_q < len_q) & ~pend_q & (~out_valid_q | out_fire);
  assign re_o     = issue;
  assign raddr_o  = ptr_q[ADDR_W-1:0];
  assign busy_o   = active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= issue;
      if (start_i.valid) begin
        active_q <= 1'b1;
        ptr_q    <= '0;
      end else begin
        if (issue) begin
          ptr_q <= ptr_q + LEN_W'(1);
        end
        if (out_fire && out_last_q) begin
          active_q <= 1'b0;
        end
      end
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i.valid) begin
      op_q  <= start_i.op;
      len_q <= start_i.len;
    end
    if (issue) begin
      pend_last_q <= (ptr_q + LEN_W'(1)) == len_q;
    end
    if (pend_q) begin
      out_data_q <= convert_case(rdata_i, op_q);
      out_last_q <= pend_last_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = op_q;
  assign m_tlast_o  = out_last_q;

endmodule

// File: hw/rtl/framed_case_convert_deframer_core.sv
// Top level of the framed case-convert deframer: register port, parser,
// payload store and drain. Depends on fccd_pkg and all fccd_* modules.
//
// Input stream: one received byte per request on s_axis. Frames are
// 0x55, operation, length, payload, 0xAA. Other bytes are discarded.
// Output stream: one converted payload byte per request on m_axis, with
// the frame's operation byte in tuser and tlast on the final byte.
// Register 0 (byte address 0) holds max_payload, reset 64; longer frames
// are refused. Only write it while the block is idle.
// While parsing, the input is always ready. After a good end byte the
// input stalls while the store is drained. The drain reads one store
// entry, then loads the converted result into the output register, and
// issues no new read until that result is loaded and the output register
// is free or being taken. A stalled receiver holds the output register
// and the drain waits. Reset returns to hunting and sets max_payload to
// 64; the store contents are not cleared and need no clearing pass.
module framed_case_convert_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic [7:0]  m_axis_tuser_o,   // [7:0] frame_operation
  output logic        m_axis_tlast_o,   // last_of_frame
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import fccd_pkg::*;

  logic [LEN_W-1:0]  max_payload_q;
  logic              cfg_wr, rx_fire, busy;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata;
  fccd_start_t       start;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i & (paddr_i[2] == REG_MAX_PAYLOAD);
  assign prdata_o = (paddr_i[2] == REG_MAX_PAYLOAD) ? {{(32-LEN_W){1'b0}}, max_payload_q}
                                                    : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr) begin
      max_payload_q <= pwdata_i[LEN_W-1:0];
    end
  end

  assign s_axis_tready_o = ~busy;
  assign rx_fire         = s_axis_tvalid_i & ~busy;

  fccd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_fire_i     (rx_fire),
    .rx_byte_i     (s_axis_tdata_i),
    .max_payload_i (max_payload_q),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .start_o       (start)
  );

  fccd_payload_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  fccd_drain u_drain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

// File: tb/framed_case_convert_deframer_core_tb.sv
// Self-checking testbench for framed_case_convert_deframer_core: feeds framed and
// stray bytes, predicts the converted payload stream and checks it field by field.
// Depends on fccd_pkg and the block's RTL only.
`timescale 1ns / 100ps

module framed_case_convert_deframer_core_tb;
  import fccd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_GAP   = 12;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned MAX_PRINTS  = 30;

  localparam logic [2:0] MAX_PAYLOAD_ADDR = 3'(4 * int'(REG_MAX_PAYLOAD));
  localparam logic [2:0] SPARE_ADDR       = 3'd4;

  typedef enum logic [2:0] {PS_HUNT, PS_OP, PS_LEN, PS_DATA, PS_END} parse_state_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] op;
    logic       last;
  } payload_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        m_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;
  logic [7:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic [31:0] prdata_o;
  logic        pready_o;

  framed_case_convert_deframer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]    rx_pending[$];
  payload_byte_t payload_expected[$];

  idle_mode_e   idle_mode = IDLE_NONE;
  logic         hold_arm = 1'b0;
  logic         hold_taken = 1'b0;
  int unsigned  hold_cnt = 0;
  int unsigned  cycle = 0;
  int unsigned  n_err = 0;
  int unsigned  n_rx = 0;
  int unsigned  n_out = 0;
  int unsigned  n_frames = 0;

  // predictor state
  parse_state_e parse_st = PS_HUNT;
  logic [6:0]   max_len = MAX_PAYLOAD_RESET;
  logic [7:0]   cur_op = 8'h00;
  logic [6:0]   frame_len = 7'd0;
  logic [6:0]   rx_count = 7'd0;
  logic [7:0]   payload_copy[PAYLOAD_DEPTH];

  function automatic int unsigned eff_limit();
    return (int'(max_len) > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(max_len);
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] b, input logic [7:0] op);
    logic is_lower;
    logic is_upper;
    is_lower = (b >= "a") && (b <= "z");
    is_upper = (b >= "A") && (b <= "Z");
    if ((op == OP_UPPER && is_lower) || (op == OP_LOWER && is_upper)) return b ^ 8'h20;
    return b;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    payload_byte_t pb;
    case (parse_st)
      PS_HUNT: begin
        if (b == START_BYTE) begin
          parse_st = PS_OP;
          rx_count = 7'd0;
        end
      end
      PS_OP: begin
        cur_op   = b;
        parse_st = PS_LEN;
      end
      PS_LEN: begin
        if (int'(b) > eff_limit()) begin
          parse_st = PS_HUNT;
        end else begin
          frame_len = b[6:0];
          rx_count  = 7'd0;
          parse_st  = (b == 8'h00) ? PS_END : PS_DATA;
        end
      end
      PS_DATA: begin
        if (rx_count < PAYLOAD_DEPTH) payload_copy[rx_count[ADDR_W-1:0]] = b;
        rx_count = rx_count + 7'd1;
        if (rx_count >= frame_len) parse_st = PS_END;
      end
      PS_END: begin
        if (b == END_BYTE) begin
          for (int i = 0; i < int'(frame_len) && i < PAYLOAD_DEPTH; i++) begin
            pb.data = flip_case(payload_copy[i], cur_op);
            pb.op   = cur_op;
            pb.last = (i + 1 == int'(frame_len));
            payload_expected.push_back(pb);
          end
        end
        parse_st = PS_HUNT;
      end
      default: parse_st = PS_HUNT;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (n_err < MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle, what);
    n_err++;
  endtask

  function automatic logic send_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 75;
      IDLE_BOTH: return $urandom_range(99) < 14;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic recv_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 75;
      IDLE_BOTH: return $urandom_range(99) < 14;
      default:   return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        parse_rx_byte(s_data);
        n_rx++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (rx_pending.size() != 0 && !send_idles()) begin
          s_valid <= 1'b1;
          s_data  <= rx_pending.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_arm && !hold_taken) begin
      hold_cnt   <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk_i) begin
    payload_byte_t pb;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (payload_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected request, out_byte %02h", m_axis_tdata_o));
      end else begin
        pb = payload_expected.pop_front();
        if (m_axis_tdata_o !== pb.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata_o, pb.data));
        if (m_axis_tuser_o !== pb.op)
          report_mismatch($sformatf("frame_operation %02h, want %02h", m_axis_tuser_o, pb.op));
        if (m_axis_tlast_o !== pb.last)
          report_mismatch($sformatf("last_of_frame %b, want %b", m_axis_tlast_o, pb.last));
      end
      n_out++;
      if (m_axis_tlast_o) n_frames++;
    end
    m_ready <= rst_ni && (hold_cnt == 0) && !recv_stalls();
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == MAX_PAYLOAD_ADDR) max_len = data[6:0];
  endtask

  task automatic apb_check_read();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAX_PAYLOAD_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (pready_o !== 1'b1)
      report_mismatch($sformatf("pready %b during read", pready_o));
    if (prdata_o !== {25'd0, max_len})
      report_mismatch($sformatf("max_payload read %0h, want %0h", prdata_o, max_len));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold until every request is out and the parser is back to hunting
  task automatic settle();
    do begin
      do @(negedge clk_i);
      while (rx_pending.size() != 0 || s_valid || payload_expected.size() != 0);
      repeat (DRAIN_GAP) @(negedge clk_i);
      if (parse_st != PS_HUNT) rx_pending.push_back(8'h00);
    end while (parse_st != PS_HUNT);
  endtask

  function automatic logic [7:0] payload_char();
    case ($urandom_range(2))
      0:       return 8'("A" + $urandom_range(25));
      1:       return 8'("a" + $urandom_range(25));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_traffic(input int unsigned budget);
    int unsigned added;
    int unsigned pick;
    int unsigned lim;
    int unsigned len;
    logic [7:0]  op;
    logic [7:0]  tail;
    added = 0;
    lim   = eff_limit();
    while (added < budget) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        rx_pending.push_back(8'($urandom));
        added++;
      end else begin
        case ($urandom_range(2))
          0:       op = OP_UPPER;
          1:       op = OP_LOWER;
          default: op = 8'($urandom);
        endcase
        if (pick < 18) len = $urandom_range(255, lim + 1);
        else len = $urandom_range((lim < 8) ? lim : 8);
        rx_pending.push_back(START_BYTE);
        rx_pending.push_back(op);
        rx_pending.push_back(8'(len));
        added += 3;
        if (len <= lim) begin
          for (int i = 0; i < int'(len); i++) rx_pending.push_back(payload_char());
          tail = END_BYTE;
          if (pick < 26) begin
            tail = 8'($urandom);
            if (tail == END_BYTE) tail = ~tail;
          end
          rx_pending.push_back(tail);
          added += len + 1;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_check_read();

    // stray bytes, both conversions at letter edges, zero length, bad end, oversize
    @(negedge clk_i);
    rx_pending = '{8'h00, 8'hFF,
                   START_BYTE, OP_UPPER, 8'd2, "a", "{", END_BYTE,
                   START_BYTE, OP_LOWER, 8'd2, "Z", "@", END_BYTE,
                   START_BYTE, 8'hFF, 8'd0, END_BYTE,
                   START_BYTE, 8'h80, 8'd1, "z", START_BYTE,
                   START_BYTE, OP_UPPER, START_BYTE};
    settle();

    // clamped limit, one full-depth frame while the receiver holds off
    apb_write(MAX_PAYLOAD_ADDR, 32'd127);
    apb_check_read();
    @(negedge clk_i);
    hold_arm = 1'b1;
    rx_pending.push_back(START_BYTE);
    rx_pending.push_back(OP_UPPER);
    rx_pending.push_back(8'(PAYLOAD_DEPTH));
    for (int i = 0; i < PAYLOAD_DEPTH; i++) rx_pending.push_back(payload_char());
    rx_pending.push_back(END_BYTE);
    add_traffic(3);
    settle();

    apb_write(MAX_PAYLOAD_ADDR, 32'd0);
    apb_write(SPARE_ADDR, 32'd3);
    apb_check_read();
    @(negedge clk_i);
    idle_mode = IDLE_SEND;
    add_traffic(6);
    settle();

    apb_write(MAX_PAYLOAD_ADDR, 32'($urandom_range(63, 1)));
    apb_check_read();
    @(negedge clk_i);
    idle_mode = IDLE_RECV;
    add_traffic(6);
    settle();

    apb_write(MAX_PAYLOAD_ADDR, 32'(PAYLOAD_DEPTH));
    apb_check_read();
    @(negedge clk_i);
    idle_mode = IDLE_BOTH;
    add_traffic(6);
    settle();

    $display("sent %0d bytes, checked %0d payload bytes in %0d frames", n_rx, n_out, n_frames);
    $display("limits 64, 127, 0, random and 64 under four idle patterns, %0d errors", n_err);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
